// ----- rtl/clpe_pkg.sv -----
package clpe_pkg;

    localparam int CAPACITY  = 256;
    localparam int DATA_BITS = 32;
    localparam int SLOT_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int POS_W     = 9;
    localparam int ACT_W     = 2;
    localparam int STAT_W    = 2;

    typedef logic [SLOT_W-1:0]           t_slot;
    typedef logic [CNT_W-1:0]            t_cnt;
    typedef logic [POS_W-1:0]            t_pos;
    typedef logic signed [DATA_BITS-1:0] t_data;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SLOT,
        S_WALK,
        S_VAL_RD,
        S_INS_RD,
        S_INS_LINK,
        S_REM_NEXT,
        S_REM_RD,
        S_DONE
    } t_state;

    // node store access for one cycle
    typedef struct packed {
        logic  link_we;
        t_slot link_waddr;
        t_slot link_wdata;
        t_slot link_raddr;
        logic  val_we;
        t_slot val_waddr;
        t_data val_wdata;
        t_slot val_raddr;
    } t_store_req;

    // free-slot stack access for one cycle
    typedef struct packed {
        logic  flush;
        t_slot rd_addr;
        logic  push;
        t_slot push_addr;
        t_slot push_data;
    } t_stack_req;

endpackage

// ----- rtl/clpe_in_if.sv -----
interface clpe_in_if import clpe_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  [ACT_W-1:0] action;
    t_pos  position;
    t_data value;

    modport source (output valid, output action, output position, output value, input ready);
    modport sink (input valid, input action, input position, input value, output ready);
endinterface

// ----- rtl/clpe_out_if.sv -----
interface clpe_out_if import clpe_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  [STAT_W-1:0] status;
    t_data read_value;
    t_pos  length;

    modport source (output valid, output status, output read_value, output length, input ready);
    modport sink (input valid, input status, input read_value, input length, output ready);
endinterface

// ----- rtl/clpe_node_store.sv -----
module clpe_node_store import clpe_pkg::*; (
    input  logic       i_clk,
    input  t_store_req i_req,
    output t_slot      o_link_rdata,
    output t_data      o_val_rdata
);

    t_slot r_links [CAPACITY];
    t_data r_vals  [CAPACITY];
    t_slot r_link_rdata;
    t_data r_val_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.link_we) begin
            r_links[i_req.link_waddr] <= i_req.link_wdata;
        end
        r_link_rdata <= r_links[i_req.link_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.val_we) begin
            r_vals[i_req.val_waddr] <= i_req.val_wdata;
        end
        r_val_rdata <= r_vals[i_req.val_raddr];
    end

    assign o_link_rdata = r_link_rdata;
    assign o_val_rdata  = r_val_rdata;

endmodule

// ----- rtl/clpe_free_stack.sv -----
module clpe_free_stack import clpe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_stack_req i_req,
    output t_slot      o_pop_slot
);

    // entries never pushed since reset or flush read as their own index
    t_slot                r_mem [CAPACITY];
    logic  [CAPACITY-1:0] r_written;
    t_slot                r_rd_data;
    t_slot                r_rd_addr;
    logic                 r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.flush) begin
            r_written <= '0;
        end else if (i_req.push) begin
            r_written[i_req.push_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            r_mem[i_req.push_addr] <= i_req.push_data;
        end
        r_rd_data <= r_mem[i_req.rd_addr];
        r_rd_hit  <= r_written[i_req.rd_addr];
        r_rd_addr <= i_req.rd_addr;
    end

    assign o_pop_slot = r_rd_hit ? r_rd_data : r_rd_addr;

endmodule

// ----- rtl/circular_list_positional_engine_top.sv -----
// Circular singly linked list engine: 256 nodes of signed 32-bit data.
// i_in (sink) takes one word per action: action, position, value.
// o_out (source) returns one word per action: status, read_value, length.
// Actions run one at a time; i_in.ready is high only while the sequencer
// is idle, and a finished word sits in the output register, so a new
// action is taken while o_out waits on a stalled receiver.
// States from accept to o_out.valid (each path ends in S_DONE), where p
// is the position and w the links walked (p-1, or count-1 to reach the
// tail when p is 0): clear, range or full error, or removing the only
// node: no other; insert into an empty list: S_SLOT; read: walk p,
// S_VAL_RD; remove: walk w, S_REM_NEXT unless p is 0, S_REM_RD; insert:
// S_SLOT, walk w, S_INS_RD unless p is 0, S_INS_LINK. The walk follows
// one next link per cycle out of the link memory; that single read port
// sets the rate. A new action can enter in the cycle after the previous
// word is loaded into the output register.
// If o_out stalls while a second word is finished, the sequencer holds in
// its last state until the output register frees up.
// Reset (synchronous, i_rst_n low) empties the list and frees every slot;
// no clearing pass is needed, the block is ready on the first idle cycle.
module circular_list_positional_engine_top import clpe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    clpe_in_if.sink    i_in,
    clpe_out_if.source o_out
);

    // sequencer state
    t_state  r_state, n_state;
    t_action r_act, n_act;
    t_pos    r_pos, n_pos;
    t_data   r_val, n_val;

    // list bookkeeping
    t_cnt    r_count, n_count;
    t_slot   r_head, n_head;
    t_cnt    r_free_top, n_free_top;

    // walk and working slots
    t_slot   r_cur, n_cur;
    logic    r_use_rd, n_use_rd;
    t_slot   r_steps, n_steps;
    t_slot   r_w, n_w;        // slot the walk stopped at (prev or tail)
    t_slot   r_new, n_new;    // slot popped for an insert
    t_slot   r_gone, n_gone;  // slot being unlinked by a remove

    // pending result and output register
    t_status r_res_status, n_res_status;
    t_data   r_res_rd, n_res_rd;
    logic    r_ovalid, n_ovalid;
    t_status r_o_status, n_o_status;
    t_data   r_o_rd, n_o_rd;
    t_pos    r_o_len, n_o_len;

    t_store_req store_req;
    t_stack_req stack_req;
    t_slot      link_rdata;
    t_data      val_rdata;
    t_slot      pop_slot;
    t_slot      cur;
    logic       accept;

    clpe_node_store u_store (
        .i_clk        (i_clk),
        .i_req        (store_req),
        .o_link_rdata (link_rdata),
        .o_val_rdata  (val_rdata)
    );

    clpe_free_stack u_stack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (stack_req),
        .o_pop_slot (pop_slot)
    );

    assign i_in.ready       = (r_state == S_IDLE);
    assign accept           = i_in.valid && i_in.ready;
    assign o_out.valid      = r_ovalid;
    assign o_out.status     = r_o_status;
    assign o_out.read_value = r_o_rd;
    assign o_out.length     = r_o_len;

    // walk pointer: the link just read, or the starting slot
    assign cur = r_use_rd ? link_rdata : r_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_head     <= '0;
            r_free_top <= t_cnt'(CAPACITY);
            r_ovalid   <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_head     <= n_head;
            r_free_top <= n_free_top;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act        <= n_act;
        r_pos        <= n_pos;
        r_val        <= n_val;
        r_cur        <= n_cur;
        r_use_rd     <= n_use_rd;
        r_steps      <= n_steps;
        r_w          <= n_w;
        r_new        <= n_new;
        r_gone       <= n_gone;
        r_res_status <= n_res_status;
        r_res_rd     <= n_res_rd;
        r_o_status   <= n_o_status;
        r_o_rd       <= n_o_rd;
        r_o_len      <= n_o_len;
    end

    always_comb begin
        n_state      = r_state;
        n_act        = r_act;
        n_pos        = r_pos;
        n_val        = r_val;
        n_count      = r_count;
        n_head       = r_head;
        n_free_top   = r_free_top;
        n_cur        = r_cur;
        n_use_rd     = r_use_rd;
        n_steps      = r_steps;
        n_w          = r_w;
        n_new        = r_new;
        n_gone       = r_gone;
        n_res_status = r_res_status;
        n_res_rd     = r_res_rd;
        n_o_status   = r_o_status;
        n_o_rd       = r_o_rd;
        n_o_len      = r_o_len;
        n_ovalid     = r_ovalid;

        store_req            = '0;
        store_req.link_raddr = cur;
        store_req.val_raddr  = cur;

        stack_req         = '0;
        stack_req.rd_addr = t_slot'(r_free_top - 1'b1);

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_act        = t_action'(i_in.action);
                    n_pos        = i_in.position;
                    n_val        = i_in.value;
                    n_res_status = STAT_OK;
                    n_res_rd     = '0;
                    n_cur        = r_head;
                    n_use_rd     = 1'b0;
                    n_state      = S_DONE;
                    case (t_action'(i_in.action))
                        ACT_INSERT: begin
                            if (i_in.position > r_count) begin
                                n_res_status = STAT_RANGE;
                            end else if (r_count >= t_cnt'(CAPACITY)) begin
                                n_res_status = STAT_FULL;
                            end else begin
                                n_state = S_SLOT;  // stack top read is in flight
                            end
                        end
                        ACT_REMOVE: begin
                            if (i_in.position >= r_count) begin
                                n_res_status = STAT_RANGE;
                            end else if (r_count == t_cnt'(1)) begin
                                // last node goes; no walk needed
                                stack_req.push      = 1'b1;
                                stack_req.push_addr = t_slot'(r_free_top);
                                stack_req.push_data = r_head;
                                n_free_top          = r_free_top + 1'b1;
                                n_head              = '0;
                                n_count             = '0;
                            end else begin
                                n_steps = (i_in.position == '0) ?
                                          t_slot'(r_count - 1'b1) :
                                          t_slot'(i_in.position - 1'b1);
                                n_state = S_WALK;
                            end
                        end
                        ACT_READ: begin
                            if (i_in.position >= r_count) begin
                                n_res_status = STAT_RANGE;
                            end else begin
                                n_steps = t_slot'(i_in.position);
                                n_state = S_WALK;
                            end
                        end
                        default: begin  // clear
                            stack_req.flush = 1'b1;
                            n_free_top      = t_cnt'(CAPACITY);
                            n_head          = '0;
                            n_count         = '0;
                        end
                    endcase
                end
            end

            S_SLOT: begin
                n_new      = pop_slot;
                n_free_top = r_free_top - 1'b1;
                if (r_count == '0) begin
                    // first node links to itself
                    store_req.link_we    = 1'b1;
                    store_req.link_waddr = pop_slot;
                    store_req.link_wdata = pop_slot;
                    store_req.val_we     = 1'b1;
                    store_req.val_waddr  = pop_slot;
                    store_req.val_wdata  = r_val;
                    n_head               = pop_slot;
                    n_count              = r_count + 1'b1;
                    n_state              = S_DONE;
                end else begin
                    n_steps = (r_pos == '0) ? t_slot'(r_count - 1'b1) :
                                              t_slot'(r_pos - 1'b1);
                    n_state = S_WALK;
                end
            end

            S_WALK: begin
                if (r_steps != '0) begin
                    n_steps  = r_steps - 1'b1;
                    n_use_rd = 1'b1;
                end else begin
                    n_w      = cur;
                    n_use_rd = 1'b0;
                    case (r_act)
                        ACT_READ: begin
                            n_state = S_VAL_RD;
                        end
                        ACT_INSERT: begin
                            if (r_pos == '0) begin
                                // new head points at old head; tail relinks next
                                store_req.link_we    = 1'b1;
                                store_req.link_waddr = r_new;
                                store_req.link_wdata = r_head;
                                store_req.val_we     = 1'b1;
                                store_req.val_waddr  = r_new;
                                store_req.val_wdata  = r_val;
                                n_state              = S_INS_LINK;
                            end else begin
                                n_state = S_INS_RD;
                            end
                        end
                        ACT_REMOVE: begin
                            if (r_pos == '0) begin
                                store_req.link_raddr = r_head;
                                n_gone               = r_head;
                                n_state              = S_REM_RD;
                            end else begin
                                n_state = S_REM_NEXT;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_VAL_RD: begin
                n_res_rd = val_rdata;
                n_state  = S_DONE;
            end

            S_INS_RD: begin
                store_req.link_we    = 1'b1;
                store_req.link_waddr = r_new;
                store_req.link_wdata = link_rdata;
                store_req.val_we     = 1'b1;
                store_req.val_waddr  = r_new;
                store_req.val_wdata  = r_val;
                n_state              = S_INS_LINK;
            end

            S_INS_LINK: begin
                store_req.link_we    = 1'b1;
                store_req.link_waddr = r_w;
                store_req.link_wdata = r_new;
                if (r_pos == '0) begin
                    n_head = r_new;
                end
                n_count = r_count + 1'b1;
                n_state = S_DONE;
            end

            S_REM_NEXT: begin
                n_gone               = link_rdata;
                store_req.link_raddr = link_rdata;
                n_state              = S_REM_RD;
            end

            S_REM_RD: begin
                store_req.link_we    = 1'b1;
                store_req.link_waddr = r_w;
                store_req.link_wdata = link_rdata;
                if (r_pos == '0) begin
                    n_head = link_rdata;
                end
                stack_req.push      = 1'b1;
                stack_req.push_addr = t_slot'(r_free_top);
                stack_req.push_data = r_gone;
                n_free_top          = r_free_top + 1'b1;
                n_count             = r_count - 1'b1;
                n_state             = S_DONE;
            end

            S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_res_status;
                    n_o_rd     = r_res_rd;
                    n_o_len    = r_count;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
